### src/aipd_pkg.sv
// Shared types and constants for the +IPD payload deframer.
// No dependencies; used by aipd_parser, aipd_obuf and at_ipd_frame_deframer.
`timescale 1ns / 1ps
`default_nettype none

package aipd_pkg;

	localparam int unsigned MAX_DIGITS_DEF = 4;
	localparam int unsigned LEN_W          = 14;
	localparam int unsigned HDR_LEN        = 7;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 14'd3000;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_OPT_CR  = 3'd1,
		PH_OPT_LF  = 3'd2,
		PH_LENGTH  = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef enum logic {
		ST_PAYLOAD = 1'b0,
		ST_BAD_LEN = 1'b1
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
		status_t    status;
	} result_t;

	// header: CR LF + I P D ,
	function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = CHAR_CR;
			3'd1:    c = CHAR_LF;
			3'd2:    c = 8'h2B;
			3'd3:    c = 8'h49;
			3'd4:    c = 8'h50;
			3'd5:    c = 8'h44;
			3'd6:    c = 8'h2C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### src/aipd_parser.sv
// Header parser and payload counter: one byte per accepted transaction.
// Depends on aipd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aipd_parser #(
	parameter int unsigned MAX_DIGITS = aipd_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [aipd_pkg::LEN_W-1:0] cfg_wdata,
	input  wire logic                       in_take,
	input  wire logic [7:0]                 in_byte,
	output logic                            res_valid,
	output aipd_pkg::result_t               res
);

	localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
	localparam int unsigned LW = aipd_pkg::LEN_W;

	aipd_pkg::phase_t phase_q, phase_d;
	logic [2:0]    pos_q, pos_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [LW-1:0] acc_q, acc_d;
	logic          ended_q, ended_d;
	logic [LW-1:0] rem_q, rem_d;
	logic [LW-1:0] max_len_q;

	logic          is_digit;
	logic [LW-1:0] dig;
	logic [LW-1:0] fb_acc;
	logic          fb_ended;
	logic [CW-1:0] fb_cnt;
	logic [LW-1:0] z_acc;
	logic          z_ended;
	logic          bad_len;
	logic          hdr_hit;

	assign is_digit = (in_byte >= aipd_pkg::CHAR_ZERO) && (in_byte <= aipd_pkg::CHAR_NINE);
	assign dig      = {{(LW-4){1'b0}}, in_byte[3:0]};

	// field byte on top of the running length
	assign fb_acc   = (!ended_q && is_digit) ? (acc_q << 3) + (acc_q << 1) + dig : acc_q;
	assign fb_ended = ended_q | ~is_digit;
	assign fb_cnt   = cnt_q + CW'(1);

	// field byte on a fresh length
	assign z_acc   = is_digit ? dig : '0;
	assign z_ended = ~is_digit;

	assign bad_len = (acc_q == '0) || (acc_q >= max_len_q);
	assign hdr_hit = (pos_q < 3'(aipd_pkg::HDR_LEN)) && (in_byte == aipd_pkg::hdr_byte(pos_q));

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		ended_d   = ended_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			aipd_pkg::PH_OPT_CR: begin
				if (in_byte == aipd_pkg::CHAR_CR) begin
					phase_d = aipd_pkg::PH_OPT_LF;
				end else if (in_byte == aipd_pkg::CHAR_LF) begin
					phase_d = aipd_pkg::PH_LENGTH;
					cnt_d   = '0;
					acc_d   = '0;
					ended_d = 1'b0;
				end else begin
					phase_d = aipd_pkg::PH_LENGTH;
					cnt_d   = CW'(1);
					acc_d   = z_acc;
					ended_d = z_ended;
				end
			end
			aipd_pkg::PH_OPT_LF: begin
				phase_d = aipd_pkg::PH_LENGTH;
				if (in_byte != aipd_pkg::CHAR_LF) begin
					cnt_d   = CW'(1);
					acc_d   = z_acc;
					ended_d = z_ended;
				end else begin
					cnt_d   = '0;
					acc_d   = '0;
					ended_d = 1'b0;
				end
			end
			aipd_pkg::PH_LENGTH: begin
				if (cnt_q == '0) begin
					cnt_d   = fb_cnt;
					acc_d   = fb_acc;
					ended_d = fb_ended;
				end else if (in_byte == aipd_pkg::CHAR_COLON && !bad_len) begin
					phase_d = aipd_pkg::PH_PAYLOAD;
					rem_d   = acc_q;
				end else if (in_byte == aipd_pkg::CHAR_COLON ||
						32'(cnt_q) >= MAX_DIGITS) begin
					res_valid  = 1'b1;
					res.status = aipd_pkg::ST_BAD_LEN;
					phase_d    = aipd_pkg::PH_HUNT;
					pos_d      = '0;
					cnt_d      = '0;
					acc_d      = '0;
					ended_d    = 1'b0;
					rem_d      = '0;
				end else begin
					cnt_d   = fb_cnt;
					acc_d   = fb_acc;
					ended_d = fb_ended;
				end
			end
			aipd_pkg::PH_PAYLOAD: begin
				res_valid     = 1'b1;
				res.data_byte = in_byte;
				res.status    = aipd_pkg::ST_PAYLOAD;
				if (rem_q <= LW'(1)) begin
					res.is_last = 1'b1;
					phase_d     = aipd_pkg::PH_HUNT;
					pos_d       = '0;
					cnt_d       = '0;
					acc_d       = '0;
					ended_d     = 1'b0;
					rem_d       = '0;
				end else begin
					rem_d = rem_q - LW'(1);
				end
			end
			default: begin
				if (hdr_hit) begin
					if (pos_q == 3'(aipd_pkg::HDR_LEN - 1)) begin
						pos_d   = '0;
						phase_d = aipd_pkg::PH_OPT_CR;
					end else begin
						pos_d = pos_q + 3'd1;
					end
				end else begin
					phase_d = aipd_pkg::PH_HUNT;
					pos_d   = (in_byte == aipd_pkg::CHAR_CR) ? 3'd1 : 3'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= aipd_pkg::PH_HUNT;
			pos_q     <= '0;
			cnt_q     <= '0;
			acc_q     <= '0;
			ended_q   <= 1'b0;
			rem_q     <= '0;
			max_len_q <= aipd_pkg::MAX_LEN_RESET;
		end else begin
			if (cfg_wen) begin
				max_len_q <= cfg_wdata;
			end
			if (in_take) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				cnt_q   <= cnt_d;
				acc_q   <= acc_d;
				ended_q <= ended_d;
				rem_q   <= rem_d;
			end
		end
	end

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == aipd_pkg::ST_BAD_LEN |-> res.data_byte == '0 && !res.is_last)
		else $error("error result carries payload bits");

	a_payload_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == aipd_pkg::PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with nothing left to count");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_DIGITS)
		else $error("length field counter overran");

	a_hunt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && res_valid && (res.is_last || res.status == aipd_pkg::ST_BAD_LEN)
		|=> phase_q == aipd_pkg::PH_HUNT && pos_q == '0 && rem_q == '0)
		else $error("frame end did not return to hunting");

endmodule

`default_nettype wire

### src/aipd_obuf.sv
// Result register with one skid entry between parser and output stream.
// Depends on aipd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aipd_obuf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire aipd_pkg::result_t  in_res,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output aipd_pkg::result_t       out_res
);

	logic              main_v_q;
	logic              skid_v_q;
	aipd_pkg::result_t main_q;
	aipd_pkg::result_t skid_q;
	logic              pop;

	assign pop       = main_v_q && out_ready;
	assign in_ready  = ~skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (!main_v_q || pop) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (in_valid) begin
			if (!main_v_q || pop) begin
				main_q <= in_res;
			end else begin
				skid_q <= in_res;
			end
		end
	end

	a_skid_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry held without a main entry");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !skid_v_q)
		else $error("result offered while buffer full");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && pop |=> main_v_q && !skid_v_q && main_q == $past(skid_q))
		else $error("skid entry not moved to main on pop");

endmodule

`default_nettype wire

### src/at_ipd_frame_deframer.sv
// A result is registered in the output buffer before it leaves on the m_ side.
// One byte per cycle while s_tready is high; the parser state updates on each accepted byte.
// s_tready drops only while the skid entry is full (m_tready held low).
// Reset (arst_n low, asynchronous): hunting for the header, buffer empty,
// max_len_exclusive back to 3000. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module at_ipd_frame_deframer #(
	parameter int unsigned MAX_DIGITS = aipd_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [aipd_pkg::LEN_W-1:0] cfg_wdata,  // max_len_exclusive
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,    // [7:0] rx_byte
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [7:0]                      m_tdata,    // [7:0] data_byte
	output logic                            m_tlast,    // is_last
	output logic [0:0]                      m_tuser     // [0] status
);

	logic              take;
	logic              res_valid;
	aipd_pkg::result_t res;
	aipd_pkg::result_t out_res;

	assign take = s_tvalid && s_tready;

	aipd_parser #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_take   (take),
		.in_byte   (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	aipd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (take && res_valid),
		.in_res    (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.data_byte;
	assign m_tlast = out_res.is_last;
	assign m_tuser = out_res.status;

endmodule

`default_nettype wire
